[sv/prefix_sum_segment_locator_macros.svh]
// Assertion macros used by the segment locator datapath.
`ifndef PREFIX_SUM_SEGMENT_LOCATOR_MACROS_SVH
`define PREFIX_SUM_SEGMENT_LOCATOR_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define PSSL_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define PSSL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define PSSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pssl_pkg.sv]
// Package with the shared types and constants of the segment locator.
`timescale 1ns / 1ps
`default_nettype none

package pssl_pkg;

    localparam int REQ_W       = 2;
    localparam int VALUE_W     = 48;
    localparam int SEG_W       = 11;
    localparam int OFS_W       = 48;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_OVF   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_EXEC    = 3'd1,
        S_ISSUE   = 3'd2,
        S_COMPARE = 3'd3,
        S_PUSH    = 3'd4
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic issue;
        logic compare;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic query_ok;
        logic search_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

[sv/pssl_ctrl.sv]
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module pssl_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire pssl_pkg::sts_t sts,
    output pssl_pkg::cmd_t   cmd
);

    pssl_pkg::ctrl_state_t state_reg;
    pssl_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pssl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            pssl_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = pssl_pkg::S_EXEC;
                end
            end
            pssl_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.query_ok)
                begin
                    state_next = pssl_pkg::S_ISSUE;
                end
                else
                begin
                    state_next = pssl_pkg::S_PUSH;
                end
            end
            pssl_pkg::S_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (sts.search_done)
                begin
                    state_next = pssl_pkg::S_PUSH;
                end
                else
                begin
                    state_next = pssl_pkg::S_COMPARE;
                end
            end
            pssl_pkg::S_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = pssl_pkg::S_ISSUE;
            end
            pssl_pkg::S_PUSH:
            begin
                cmd.push = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = pssl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pssl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/pssl_datapath.sv]
// Datapath with the prefix-sum table, search registers and output register.
`timescale 1ns / 1ps
`default_nettype none

`include "prefix_sum_segment_locator_macros.svh"

module pssl_datapath #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int SUM_BITS     = 48
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire pssl_pkg::cmd_t            cmd,
    input  wire [pssl_pkg::REQ_W-1:0]      in_req_type,
    input  wire [pssl_pkg::VALUE_W-1:0]    in_value,
    input  wire                            out_ready,
    output pssl_pkg::sts_t                 sts,
    output logic                           out_valid,
    output logic [pssl_pkg::SEG_W-1:0]     out_segment_index,
    output logic [pssl_pkg::OFS_W-1:0]     out_offset,
    output logic [pssl_pkg::STAT_W-1:0]    out_status
);

    localparam int ADDR_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int CMP_W  = (SUM_BITS > pssl_pkg::VALUE_W) ? SUM_BITS : pssl_pkg::VALUE_W;
    localparam int SEGX_W = pssl_pkg::SEG_W + CNT_W + 1;

    logic [SUM_BITS-1:0] table_mem [MAX_SEGMENTS];

    pssl_pkg::req_type_t          req_reg;
    logic [pssl_pkg::VALUE_W-1:0] pos_reg;
    logic [SUM_BITS-1:0]          rdata_reg;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_BITS-1:0] total_reg, total_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [SUM_BITS-1:0] before_reg, before_next;

    logic [pssl_pkg::SEG_W-1:0] res_index_reg, res_index_next;
    logic [pssl_pkg::OFS_W-1:0] res_offset_reg, res_offset_next;
    pssl_pkg::status_t          res_status_reg, res_status_next;

    logic                       out_valid_reg, out_valid_next;
    logic [pssl_pkg::SEG_W-1:0] out_index_reg;
    logic [pssl_pkg::OFS_W-1:0] out_offset_reg;
    pssl_pkg::status_t          out_status_reg;

    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  total_ext;
    logic [CMP_W:0]    sum_wide;
    logic [CMP_W:0]    sum_limit;
    logic              append_ovf;
    logic              table_full;
    logic              range_err;
    logic              append_ok;
    logic [CNT_W-1:0]  mid;
    logic              search_done;
    logic              rd_less;
    logic [CNT_W:0]    seg_wide;
    logic [SEGX_W-1:0] seg_ext;
    logic [CMP_W-1:0]  ofs_diff;

    always_comb
    begin
        pos_ext     = CMP_W'(pos_reg);
        total_ext   = CMP_W'(total_reg);
        sum_wide    = {1'b0, total_ext} + {1'b0, pos_ext};
        sum_limit   = ((CMP_W + 1)'(1) << SUM_BITS) - (CMP_W + 1)'(1);
        append_ovf  = sum_wide > sum_limit;
        table_full  = count_reg == CNT_W'(MAX_SEGMENTS);
        range_err   = (pos_reg == '0) || (pos_ext > total_ext);
        append_ok   = cmd.exec && (req_reg == pssl_pkg::REQ_APPEND) && !table_full
                      && !append_ovf;
        mid         = lo_reg + ((hi_reg - lo_reg) >> 1);
        search_done = lo_reg >= hi_reg;
        rd_less     = CMP_W'(rdata_reg) < pos_ext;
        seg_wide    = {1'b0, lo_reg} + (CNT_W + 1)'(1);
        seg_ext     = SEGX_W'(seg_wide);
        ofs_diff    = pos_ext - CMP_W'(before_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= pssl_pkg::req_type_t'(in_req_type);
            pos_reg <= in_value;
        end
        if (append_ok)
        begin
            table_mem[count_reg[ADDR_W-1:0]] <= sum_wide[SUM_BITS-1:0];
        end
        if (cmd.issue && !search_done)
        begin
            rdata_reg <= table_mem[mid[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        total_next      = total_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        before_next     = before_reg;
        res_index_next  = res_index_reg;
        res_offset_next = res_offset_reg;
        res_status_next = res_status_reg;

        if (cmd.exec)
        begin
            res_index_next  = '0;
            res_offset_next = '0;
            res_status_next = pssl_pkg::STAT_OK;
            case (req_reg)
                pssl_pkg::REQ_CLEAR:
                begin
                    count_next = '0;
                    total_next = '0;
                end
                pssl_pkg::REQ_APPEND:
                begin
                    if (table_full)
                    begin
                        res_status_next = pssl_pkg::STAT_FULL;
                    end
                    else if (append_ovf)
                    begin
                        res_status_next = pssl_pkg::STAT_OVF;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        total_next = sum_wide[SUM_BITS-1:0];
                    end
                end
                pssl_pkg::REQ_QUERY:
                begin
                    if (range_err)
                    begin
                        res_status_next = pssl_pkg::STAT_RANGE;
                    end
                    lo_next     = '0;
                    hi_next     = count_reg;
                    before_next = '0;
                end
                default:
                begin
                    res_status_next = pssl_pkg::STAT_OK;
                end
            endcase
        end

        if (cmd.issue && search_done)
        begin
            res_index_next  = seg_ext[pssl_pkg::SEG_W-1:0];
            res_offset_next = ofs_diff[pssl_pkg::OFS_W-1:0];
            res_status_next = pssl_pkg::STAT_OK;
        end

        if (cmd.compare)
        begin
            if (rd_less)
            begin
                lo_next     = mid + CNT_W'(1);
                before_next = rdata_reg;
            end
            else
            begin
                hi_next = mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        before_reg     <= before_next;
        res_index_reg  <= res_index_next;
        res_offset_reg <= res_offset_next;
        res_status_reg <= res_status_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_index_reg  <= res_index_reg;
            out_offset_reg <= res_offset_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign sts.query_ok    = (req_reg == pssl_pkg::REQ_QUERY) && !range_err;
    assign sts.search_done = search_done;
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid         = out_valid_reg;
    assign out_segment_index = out_index_reg;
    assign out_offset        = out_offset_reg;
    assign out_status        = out_status_reg;

    `PSSL_ASSERT_NOW(a_count_bound, count_reg <= CNT_W'(MAX_SEGMENTS), "segment count past capacity")
    `PSSL_ASSERT_IMPLY(a_search_window, cmd.compare, (lo_reg < hi_reg) && (hi_reg <= count_reg), "search window outside table")
    `PSSL_ASSERT_NEXT(a_clear_empties, cmd.exec && (req_reg == pssl_pkg::REQ_CLEAR), (count_reg == '0) && (total_reg == '0), "clear left table contents")
    `PSSL_ASSERT_NEXT(a_push_shows, cmd.push, out_valid_reg, "result not presented after push")

endmodule

`default_nettype wire

[sv/prefix_sum_segment_locator.sv]
// Top level of the prefix-sum segment locator with stream ports.
`timescale 1ns / 1ps
`default_nettype none

// Keeps appended segment sizes as running prefix sums in a table and answers position
// queries with the 1-based segment index and offset inside it. One request is worked on
// at a time. A clear, an append or a rejected query goes from acceptance through the execute
// and push states to its result in the output register. An accepted query runs a binary
// search between those states; each halving step has an issue state for the registered
// table read and a compare state for the compare. The next request is taken once the
// previous result has moved into the output register, even while that result still waits.

module prefix_sum_segment_locator #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int SUM_BITS     = 48
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire [pssl_pkg::IN_TDATA_W-1:0]       s_axis_tdata,   // value
    input  wire [pssl_pkg::REQ_W-1:0]            s_axis_tuser,   // req_type
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [pssl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // segment_index, offset
    output logic [pssl_pkg::STAT_W-1:0]          m_axis_tuser    // status
);

    localparam int PAD_W = pssl_pkg::OUT_TDATA_W - pssl_pkg::SEG_W - pssl_pkg::OFS_W;

    pssl_pkg::cmd_t cmd;
    pssl_pkg::sts_t sts;

    logic [pssl_pkg::SEG_W-1:0] segment_index;
    logic [pssl_pkg::OFS_W-1:0] offset;

    pssl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pssl_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .SUM_BITS     (SUM_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .in_req_type       (s_axis_tuser),
        .in_value          (s_axis_tdata),
        .out_ready         (m_axis_tready),
        .sts               (sts),
        .out_valid         (m_axis_tvalid),
        .out_segment_index (segment_index),
        .out_offset        (offset),
        .out_status        (m_axis_tuser)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, offset, segment_index};

endmodule

`default_nettype wire
